[src/drld_pkg.sv]
package drld_pkg;

  // decoder phase within one run
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  // largest length or offset field, in bytes
  localparam logic [3:0] MAX_FIELD_BYTES = 4'd4;

  // one result item as held in the output queue
  typedef struct packed {
    logic [31:0] run_start;
    logic [31:0] run_length;
    logic        sparse_run;
    logic        list_end;
    logic        bad_format;
  } run_item_t;

  // push request from the decoder to the output queue
  typedef struct packed {
    logic first;
    logic second;
  } push_req_t;

endpackage

[src/drld_in_if.sv]
interface drld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_last;

  modport source (output valid, data_byte, region_last, input ready);
  modport sink (input valid, data_byte, region_last, output ready);
endinterface

[src/drld_out_if.sv]
interface drld_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] run_start;
  logic [31:0] run_length;
  logic        sparse_run;
  logic        list_end;
  logic        bad_format;

  modport source (output valid, run_start, run_length, sparse_run, list_end, bad_format,
                  input ready);
  modport sink (input valid, run_start, run_length, sparse_run, list_end, bad_format,
                output ready);
endinterface

[src/data_run_list_decoder_unit.sv]
// a result item is registered into the output queue with the byte that completes it
// throughput: one byte per cycle while the output queue has room; a run closed by the region's
//   last byte gives two items, both written together into the output queue of OUT_DEPTH
// input ready drops only while the output queue lacks room for two items
// reset (rst, synchronous, active high) returns to expecting a header with the
//   running cluster at zero and the output queue empty
module data_run_list_decoder_unit #(
  parameter int OUT_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  drld_in_if.sink    bytes_in,
  drld_out_if.source runs_out
);

  drld_pkg::phase_t    phase;
  drld_pkg::phase_t    phase_next;
  logic [3:0]          length_size;
  logic [3:0]          length_size_next;
  logic [3:0]          offset_size;
  logic [3:0]          offset_size_next;
  logic [3:0]          byte_count;
  logic [3:0]          byte_count_next;
  logic [31:0]         length_accum;
  logic [31:0]         length_accum_next;
  logic [31:0]         offset_accum;
  logic [31:0]         offset_accum_next;
  logic [31:0]         current_cluster;
  logic [31:0]         current_cluster_next;

  logic                accept;
  logic                room;
  logic [7:0]          b;
  logic                last;
  logic [3:0]          ls;
  logic [3:0]          os;
  logic [31:0]         byte_shifted;
  logic [31:0]         off_upd;
  logic [31:0]         off_ext;
  logic [3:0]          cnt;
  logic                fin;
  logic                term;
  logic                term_bad;
  drld_pkg::push_req_t push;
  drld_pkg::run_item_t item_a;
  drld_pkg::run_item_t item_b;

  assign bytes_in.ready = room;
  assign accept = bytes_in.valid && room;
  assign b      = bytes_in.data_byte;
  assign last   = bytes_in.region_last;
  assign ls     = b[3:0];
  assign os     = b[7:4];
  assign cnt    = byte_count + 4'd1;

  // place the byte at its little-endian position
  assign byte_shifted = {24'd0, b} << {byte_count[1:0], 3'b000};
  assign off_upd      = offset_accum | byte_shifted;

  // sign-extend the offset from its field size
  always_comb begin
    case (offset_size)
      4'd1:    off_ext = {{24{off_upd[7]}}, off_upd[7:0]};
      4'd2:    off_ext = {{16{off_upd[15]}}, off_upd[15:0]};
      4'd3:    off_ext = {{8{off_upd[23]}}, off_upd[23:0]};
      default: off_ext = off_upd;
    endcase
  end

  // per-byte decode and state update
  always_comb begin
    phase_next           = phase;
    length_size_next     = length_size;
    offset_size_next     = offset_size;
    byte_count_next      = byte_count;
    length_accum_next    = length_accum;
    offset_accum_next    = offset_accum;
    current_cluster_next = current_cluster;
    fin                  = 1'b0;
    term                 = 1'b0;
    term_bad             = 1'b0;
    push                 = '0;
    item_a               = '0;
    item_b               = '0;
    item_b.list_end      = 1'b1;

    if (accept) begin
      case (phase)
        drld_pkg::PH_HEADER: begin
          if (b == 8'd0) begin
            term = 1'b1;
          end else if (ls > drld_pkg::MAX_FIELD_BYTES || os > drld_pkg::MAX_FIELD_BYTES ||
                       last) begin
            term     = 1'b1;
            term_bad = 1'b1;
          end else begin
            length_size_next  = ls;
            offset_size_next  = os;
            byte_count_next   = '0;
            length_accum_next = '0;
            offset_accum_next = '0;
            phase_next = (ls != 4'd0) ? drld_pkg::PH_LENGTH : drld_pkg::PH_OFFSET;
          end
        end
        drld_pkg::PH_LENGTH: begin
          length_accum_next = length_accum | byte_shifted;
          if (cnt >= length_size) begin
            byte_count_next = '0;
            if (offset_size == 4'd0) begin
              fin = 1'b1;
            end else begin
              phase_next = drld_pkg::PH_OFFSET;
            end
          end else begin
            byte_count_next = cnt;
          end
          if (!fin && last) begin
            term     = 1'b1;
            term_bad = 1'b1;
          end
        end
        drld_pkg::PH_OFFSET: begin
          offset_accum_next = off_upd;
          if (cnt >= offset_size) begin
            fin = 1'b1;
          end else begin
            byte_count_next = cnt;
            if (last) begin
              term     = 1'b1;
              term_bad = 1'b1;
            end
          end
        end
        default: begin
          if (last) begin
            phase_next = drld_pkg::PH_HEADER;
          end
        end
      endcase
    end

    // complete run: emit it, then the terminator if the region ends here
    if (fin) begin
      if (offset_size != 4'd0) begin
        current_cluster_next = current_cluster + off_ext;
      end
      push.first        = 1'b1;
      item_a.run_start  = current_cluster_next;
      item_a.run_length = length_accum_next;
      item_a.sparse_run = (offset_size == 4'd0);
      if (last) begin
        push.second          = 1'b1;
        current_cluster_next = '0;
      end
    end

    // terminator only
    if (term) begin
      push.first           = 1'b1;
      item_a.list_end      = 1'b1;
      item_a.bad_format    = term_bad;
      current_cluster_next = '0;
    end

    // any end of run clears the run fields
    if (fin || term) begin
      length_size_next  = '0;
      offset_size_next  = '0;
      byte_count_next   = '0;
      length_accum_next = '0;
      offset_accum_next = '0;
      phase_next = (term && !last) ? drld_pkg::PH_SKIP : drld_pkg::PH_HEADER;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= drld_pkg::PH_HEADER;
      length_size     <= '0;
      offset_size     <= '0;
      byte_count      <= '0;
      length_accum    <= '0;
      offset_accum    <= '0;
      current_cluster <= '0;
    end else begin
      phase           <= phase_next;
      length_size     <= length_size_next;
      offset_size     <= offset_size_next;
      byte_count      <= byte_count_next;
      length_accum    <= length_accum_next;
      offset_accum    <= offset_accum_next;
      current_cluster <= current_cluster_next;
    end
  end

  // result queue
  drld_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item_a (item_a),
    .item_b (item_b),
    .room   (room),
    .out_ch (runs_out)
  );

  a_second_is_clean_end: assert property (@(posedge clk) disable iff (rst)
    push.second |-> (item_b.list_end && !item_b.bad_format && item_a.list_end == 1'b0))
    else $error("second item is not a clean terminator after a run");

  a_end_clears_cluster: assert property (@(posedge clk) disable iff (rst)
    (push.first && (item_a.list_end || push.second)) |=> current_cluster == 32'd0)
    else $error("running cluster not cleared at list end");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push.first |-> accept)
    else $error("result pushed without an accepted byte");

  a_run_has_no_bad: assert property (@(posedge clk) disable iff (rst)
    (push.first && !item_a.list_end) |-> !item_a.bad_format)
    else $error("run item flagged bad");

endmodule

[src/drld_out_fifo.sv]
module drld_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  drld_pkg::push_req_t push,
  input  drld_pkg::run_item_t item_a,
  input  drld_pkg::run_item_t item_b,
  output logic                room,
  drld_out_if.source          out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  drld_pkg::run_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;
  logic [AW-1:0] wr_ptr_b;
  logic [1:0]    push_n;

  // room for a worst-case item pair
  assign room = (count <= CW'(DEPTH - 2));

  assign pop      = out_ch.valid && out_ch.ready;
  assign wr_ptr_b = wr_ptr + AW'(1);
  assign push_n   = {1'b0, push.first} + {1'b0, push.second};

  // head of queue drives the output channel
  assign out_ch.valid      = (count != '0);
  assign out_ch.run_start  = mem[rd_ptr].run_start;
  assign out_ch.run_length = mem[rd_ptr].run_length;
  assign out_ch.sparse_run = mem[rd_ptr].sparse_run;
  assign out_ch.list_end   = mem[rd_ptr].list_end;
  assign out_ch.bad_format = mem[rd_ptr].bad_format;

  assign count_next = count + CW'(push_n) - CW'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= item_a;
    end
    if (push.second) begin
      mem[wr_ptr_b] <= item_b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("output queue overfilled");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second push without first");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.first) |=> count == $past(count) - CW'(1))
    else $error("fill count wrong after pop");

endmodule
